// File: rtl/greedy_grid_path_walker_top_macros.svh
// ----------------------------------------------------------------------------
// greedy grid path walker assertion macros
// concurrent checks shared by the walker rtl
// ----------------------------------------------------------------------------
`ifndef GREEDY_GRID_PATH_WALKER_TOP_MACROS_SVH
`define GREEDY_GRID_PATH_WALKER_TOP_MACROS_SVH

// condition must never hold at a clock edge outside reset
`define GGW_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

// antecedent at one edge forces the consequent at the next edge
`define GGW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ggw_pkg.sv
// ----------------------------------------------------------------------------
// ggw_pkg
// shared constants, codes and types of the greedy grid path walker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ggw_pkg;

  localparam int COORD_W       = 5;
  localparam int COORD_LIMIT   = 32;
  localparam int DEF_GRID_SIDE = 32;
  localparam int DIST_W        = COORD_W + 2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_START = 2'd2,
    OP_STEP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_ACK   = 2'd0,
    ST_MOVED = 2'd1,
    ST_GOAL  = 2'd2,
    ST_STUCK = 2'd3
  } status_t;

  // single cell write into a row memory
  typedef struct packed {
    logic               en;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               val;
  } wr_req_t;

endpackage

// File: rtl/ggw_rowmem.sv
// ----------------------------------------------------------------------------
// ggw_rowmem
// row-wide bitmap memory with per-row valid bits; an unwritten row reads zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ggw_rowmem #(
  parameter int ROWS = ggw_pkg::DEF_GRID_SIDE,
  parameter int COLS = ggw_pkg::DEF_GRID_SIDE
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clr,
  input  ggw_pkg::wr_req_t        wr,
  input  logic                    rd_en,
  input  logic [$clog2(ROWS)-1:0] rd_row,
  output logic [COLS-1:0]         rd_data
);
  import ggw_pkg::*;

  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] rv;
  logic [ROW_W-1:0] wr_row;
  logic [COL_W-1:0] wr_col;

  assign wr_row = wr.row[ROW_W-1:0];
  assign wr_col = wr.col[COL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      rv <= '0;
    end else if (wr.en) begin
      rv[wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (rv[wr_row]) begin
        mem[wr_row][wr_col] <= wr.val;
      end else begin
        // first write to a row also clears the rest of it
        mem[wr_row] <= wr.val ? (COLS'(1) << wr_col) : '0;
      end
    end
    if (rd_en) begin
      rd_data <= rv[rd_row] ? mem[rd_row] : '0;
    end
  end

endmodule

// File: rtl/greedy_grid_path_walker_top.sv
// ----------------------------------------------------------------------------
// greedy_grid_path_walker_top
// greedy best-first walker over a walkable and a visited bitmap
// a taken beat waits in the input register; its result is registered once the
// row window is loaded and the output is free; one beat per cycle while neither
// stalls, but a vertical move or a walk start holds the next beat while rows refill
// reset: synchronous; bitmaps read as zero via row valid bits, no clearing pass
// the window of three rows is fetched one row at a time after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "greedy_grid_path_walker_top_macros.svh"

module greedy_grid_path_walker_top #(
  parameter int GRID_SIDE = ggw_pkg::DEF_GRID_SIDE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  op,
  input  logic [ggw_pkg::COORD_W-1:0] cell_x,
  input  logic [ggw_pkg::COORD_W-1:0] cell_y,
  input  logic                        walkable,
  input  logic [ggw_pkg::COORD_W-1:0] goal_x,
  input  logic [ggw_pkg::COORD_W-1:0] goal_y,
  input  logic                        retry,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ggw_pkg::COORD_W-1:0] pos_x,
  output logic [ggw_pkg::COORD_W-1:0] pos_y,
  output logic [1:0]                  status
);
  import ggw_pkg::*;

  localparam int LIMIT = (GRID_SIDE < COORD_LIMIT) ? GRID_SIDE : COORD_LIMIT;
  localparam int IDX_W = $clog2(LIMIT);
  localparam logic [COORD_W:0] LIMIT_C = (COORD_W + 1)'(LIMIT);

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [1:0] SLOT_UP   = 2'd0;
  localparam logic [1:0] SLOT_MID  = 2'd1;
  localparam logic [1:0] SLOT_DOWN = 2'd2;
  localparam logic [1:0] NB_SLOT [4] = '{SLOT_UP, SLOT_DOWN, SLOT_MID, SLOT_MID};

  function automatic logic [COORD_W:0] absd(input logic [COORD_W:0] a,
                                            input logic [COORD_W:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // input register
  logic               hv;
  op_t                h_op;
  logic [COORD_W-1:0] h_x, h_y, h_gx, h_gy;
  logic               h_walk, h_retry;

  // walker state
  logic [COORD_W-1:0] cur_x, cur_y, tgt_x, tgt_y;
  logic [COORD_W-1:0] cur_x_next, cur_y_next, tgt_x_next, tgt_y_next;
  logic               no_mark, no_mark_next;

  // three-row window around the walker: up, mid, down
  logic [LIMIT-1:0] win_walk [3];
  logic [LIMIT-1:0] win_vis  [3];
  logic [LIMIT-1:0] win_walk_next [3];
  logic [LIMIT-1:0] win_vis_next  [3];
  logic [2:0]       loaded, loaded_next;
  logic             rd_pend, rd_pend_next;
  logic [1:0]       rd_slot, rd_slot_next;
  logic             win_ok;

  logic             accept, fire;
  logic             rd_en;
  logic [IDX_W-1:0] rd_row;
  logic [LIMIT-1:0] walk_rd, vis_rd;
  wr_req_t          walk_wr, vis_wr;
  logic             vis_clr;
  status_t          res_status;

  logic [COORD_W:0]  cx6, cy6, tx6, ty6, row6;
  logic [COORD_W:0]  nb_x [4];
  logic [COORD_W:0]  nb_y [4];
  logic [3:0]        nb_open;
  logic [DIST_W-1:0] nb_h [4];
  logic              best_any;
  logic [1:0]        best_k;
  logic [DIST_W-1:0] best_h;
  logic              at_goal, cell_in, fill_found;
  logic [1:0]        fill_slot;
  logic [COORD_W-1:0] mv_x, mv_y;

  assign win_ok   = &loaded;
  assign fire     = hv && win_ok && (!out_valid || !out_stall);
  assign in_stall = hv && !fire;
  assign accept   = in_valid && !in_stall;
  assign vis_clr  = fire && (h_op == OP_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
    end else begin
      hv <= accept || (hv && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_op    <= op_t'(op);
      h_x     <= cell_x;
      h_y     <= cell_y;
      h_walk  <= walkable;
      h_gx    <= goal_x;
      h_gy    <= goal_y;
      h_retry <= retry;
    end
  end

  // neighbor evaluation
  always_comb begin
    cx6 = {1'b0, cur_x};
    cy6 = {1'b0, cur_y};
    tx6 = {1'b0, tgt_x};
    ty6 = {1'b0, tgt_y};
    nb_x[DIR_UP]    = cx6;
    nb_y[DIR_UP]    = cy6 - 1'b1;
    nb_x[DIR_DOWN]  = cx6;
    nb_y[DIR_DOWN]  = cy6 + 1'b1;
    nb_x[DIR_LEFT]  = cx6 - 1'b1;
    nb_y[DIR_LEFT]  = cy6;
    nb_x[DIR_RIGHT] = cx6 + 1'b1;
    nb_y[DIR_RIGHT] = cy6;
    for (int k = 0; k < 4; k++) begin
      // wrap below zero lands past the limit, so one compare covers both edges
      nb_open[k] = (nb_x[k] < LIMIT_C) && (nb_y[k] < LIMIT_C) &&
                   win_walk[NB_SLOT[k]][nb_x[k][IDX_W-1:0]] &&
                   !win_vis[NB_SLOT[k]][nb_x[k][IDX_W-1:0]];
      nb_h[k] = DIST_W'(absd(nb_x[k], tx6)) + DIST_W'(absd(nb_y[k], ty6));
    end
    best_any = 1'b0;
    best_k   = DIR_UP;
    best_h   = '0;
    for (int k = 0; k < 4; k++) begin
      if (nb_open[k] && (!best_any || (nb_h[k] < best_h))) begin
        best_any = 1'b1;
        best_k   = 2'(k);
        best_h   = nb_h[k];
      end
    end
    at_goal = (cur_x == tgt_x) && (cur_y == tgt_y);
    cell_in = ({1'b0, h_x} < LIMIT_C) && ({1'b0, h_y} < LIMIT_C);
    mv_x    = nb_x[best_k][COORD_W-1:0];
    mv_y    = nb_y[best_k][COORD_W-1:0];
  end

  // next state, window fill and memory requests
  always_comb begin
    cur_x_next    = cur_x;
    cur_y_next    = cur_y;
    tgt_x_next    = tgt_x;
    tgt_y_next    = tgt_y;
    no_mark_next  = no_mark;
    win_walk_next = win_walk;
    win_vis_next  = win_vis;
    loaded_next   = loaded;
    rd_pend_next  = 1'b0;
    rd_slot_next  = rd_slot;
    rd_en         = 1'b0;
    rd_row        = '0;
    walk_wr       = '0;
    vis_wr        = '0;
    res_status    = ST_ACK;
    fill_found    = 1'b0;
    fill_slot     = SLOT_UP;
    row6          = '0;

    if (rd_pend) begin
      win_walk_next[rd_slot] = walk_rd;
      win_vis_next[rd_slot]  = vis_rd;
      loaded_next[rd_slot]   = 1'b1;
    end

    for (int i = 0; i < 3; i++) begin
      if (!fill_found && !loaded[i] && !(rd_pend && (rd_slot == 2'(i)))) begin
        fill_found = 1'b1;
        fill_slot  = 2'(i);
      end
    end
    if (fill_found) begin
      row6 = cy6 + {{(COORD_W - 1){1'b0}}, fill_slot} - 1'b1;
      if (row6 < LIMIT_C) begin
        rd_en        = 1'b1;
        rd_row       = row6[IDX_W-1:0];
        rd_pend_next = 1'b1;
        rd_slot_next = fill_slot;
      end else begin
        // row past the grid edge is all blocked
        win_walk_next[fill_slot] = '0;
        win_vis_next[fill_slot]  = '0;
        loaded_next[fill_slot]   = 1'b1;
      end
    end

    if (fire) begin
      unique case (h_op)
        OP_WRITE: begin
          if (cell_in) begin
            walk_wr = '{en: 1'b1, row: h_y, col: h_x, val: h_walk};
            for (int i = 0; i < 3; i++) begin
              if ((cy6 + (COORD_W + 1)'(i) - 1'b1) == {1'b0, h_y}) begin
                win_walk_next[i][h_x[IDX_W-1:0]] = h_walk;
              end
            end
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < 3; i++) begin
            win_vis_next[i] = '0;
          end
        end
        OP_START: begin
          cur_x_next   = h_x;
          cur_y_next   = h_y;
          tgt_x_next   = h_gx;
          tgt_y_next   = h_gy;
          no_mark_next = h_retry;
          loaded_next  = '0;
          if (!h_retry && cell_in) begin
            vis_wr = '{en: 1'b1, row: h_y, col: h_x, val: 1'b1};
          end
        end
        OP_STEP: begin
          if (at_goal) begin
            res_status = ST_GOAL;
          end else if (!best_any) begin
            res_status = ST_STUCK;
          end else begin
            res_status = ST_MOVED;
            cur_x_next = mv_x;
            cur_y_next = mv_y;
            if (best_k == DIR_UP) begin
              win_walk_next[SLOT_MID]  = win_walk[SLOT_UP];
              win_walk_next[SLOT_DOWN] = win_walk[SLOT_MID];
              win_vis_next[SLOT_MID]   = win_vis[SLOT_UP];
              win_vis_next[SLOT_DOWN]  = win_vis[SLOT_MID];
              loaded_next[SLOT_UP]     = 1'b0;
            end else if (best_k == DIR_DOWN) begin
              win_walk_next[SLOT_MID]  = win_walk[SLOT_DOWN];
              win_walk_next[SLOT_UP]   = win_walk[SLOT_MID];
              win_vis_next[SLOT_MID]   = win_vis[SLOT_DOWN];
              win_vis_next[SLOT_UP]    = win_vis[SLOT_MID];
              loaded_next[SLOT_DOWN]   = 1'b0;
            end
            if (!no_mark) begin
              win_vis_next[SLOT_MID][mv_x[IDX_W-1:0]] = 1'b1;
              vis_wr = '{en: 1'b1, row: mv_y, col: mv_x, val: 1'b1};
            end
          end
        end
        default: begin
          res_status = ST_ACK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x   <= '0;
      cur_y   <= '0;
      tgt_x   <= '0;
      tgt_y   <= '0;
      no_mark <= 1'b0;
      loaded  <= '0;
      rd_pend <= 1'b0;
      rd_slot <= SLOT_UP;
    end else begin
      cur_x   <= cur_x_next;
      cur_y   <= cur_y_next;
      tgt_x   <= tgt_x_next;
      tgt_y   <= tgt_y_next;
      no_mark <= no_mark_next;
      loaded  <= loaded_next;
      rd_pend <= rd_pend_next;
      rd_slot <= rd_slot_next;
    end
  end

  always_ff @(posedge clk) begin
    win_walk <= win_walk_next;
    win_vis  <= win_vis_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pos_x  <= cur_x_next;
      pos_y  <= cur_y_next;
      status <= res_status;
    end
  end

  ggw_rowmem #(
    .ROWS (LIMIT),
    .COLS (LIMIT)
  ) u_walk_mem (
    .clk     (clk),
    .rst     (rst),
    .clr     (1'b0),
    .wr      (walk_wr),
    .rd_en   (rd_en),
    .rd_row  (rd_row),
    .rd_data (walk_rd)
  );

  ggw_rowmem #(
    .ROWS (LIMIT),
    .COLS (LIMIT)
  ) u_vis_mem (
    .clk     (clk),
    .rst     (rst),
    .clr     (vis_clr),
    .wr      (vis_wr),
    .rd_en   (rd_en),
    .rd_row  (rd_row),
    .rd_data (vis_rd)
  );

  `GGW_ASSERT_NEVER(a_no_fetch_on_fire, clk, rst, rd_en && fire, "row fetch during item")
  `GGW_ASSERT_NEVER(a_pend_not_ok, clk, rst, rd_pend && win_ok, "window ready with fetch open")
  `GGW_ASSERT_NEXT(a_start_refill, clk, rst, fire && (h_op == OP_START), !win_ok, "start kept window")
  `GGW_ASSERT_NEXT(a_move_changes, clk, rst, fire && (res_status == ST_MOVED), (cur_x != $past(cur_x)) || (cur_y != $past(cur_y)), "move left position")

endmodule

// File: verif/greedy_grid_path_walker_top_test.sv
// ----------------------------------------------------------------------------
// greedy_grid_path_walker_top_test
// drives map writes, visited clears, walk starts and steps into the walker
// under random idling on both sides, and checks every result beat against a
// local model of the bitmaps, walker position and goal
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module greedy_grid_path_walker_top_test;

  import ggw_pkg::*;

  localparam int GRID = DEF_GRID_SIDE;

  typedef struct {
    op_t          op;
    bit [COORD_W-1:0] cx;
    bit [COORD_W-1:0] cy;
    bit           wk;
    bit [COORD_W-1:0] gx;
    bit [COORD_W-1:0] gy;
    bit           rt;
  } walk_item_t;

  typedef struct {
    bit [COORD_W-1:0] pos_x;
    bit [COORD_W-1:0] pos_y;
    status_t      status;
  } walk_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           op = OP_WRITE;
  logic [COORD_W-1:0]   cell_x = '0;
  logic [COORD_W-1:0]   cell_y = '0;
  logic                 walkable = 1'b0;
  logic [COORD_W-1:0]   goal_x = '0;
  logic [COORD_W-1:0]   goal_y = '0;
  logic                 retry = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COORD_W-1:0]   pos_x;
  logic [COORD_W-1:0]   pos_y;
  logic [1:0]           status;

  greedy_grid_path_walker_top #(.GRID_SIDE(GRID)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .cell_x    (cell_x),
    .cell_y    (cell_y),
    .walkable  (walkable),
    .goal_x    (goal_x),
    .goal_y    (goal_y),
    .retry     (retry),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .status    (status)
  );

  always #10 clk = ~clk;

  // model state
  bit               open_cells [GRID*GRID];
  bit               seen_cells [GRID*GRID];
  bit [COORD_W-1:0] walker_x, walker_y, aim_x, aim_y;
  bit               free_walk;

  walk_result_t     expected_positions [$];
  int               mismatches;
  int               beats_sent;
  bit               idle_en;

  // long receiver hold-off, requested by the test and counted by the rx process
  int unsigned      hold_req_len;
  int unsigned      hold_req_seq;
  int unsigned      hold_seen_seq;
  int unsigned      hold_left;
  int unsigned      rx_burst_left;

  function automatic bit on_grid(int x, int y);
    return x >= 0 && y >= 0 && x < GRID && y < GRID && x < COORD_LIMIT && y < COORD_LIMIT;
  endfunction

  function automatic void predict_walker(walk_item_t it);
    int           dx [4] = '{0, 0, -1, 1};
    int           dy [4] = '{-1, 1, 0, 0};
    int           best, best_h, h, nx, ny, k;
    walk_result_t r;
    r.status = ST_ACK;
    case (it.op)
      OP_WRITE: begin
        if (on_grid(int'(it.cx), int'(it.cy))) open_cells[it.cy*GRID + it.cx] = it.wk;
      end
      OP_CLEAR: begin
        foreach (seen_cells[i]) seen_cells[i] = 1'b0;
      end
      OP_START: begin
        walker_x  = it.cx;
        walker_y  = it.cy;
        aim_x     = it.gx;
        aim_y     = it.gy;
        free_walk = it.rt;
        if (!free_walk && on_grid(int'(it.cx), int'(it.cy)))
          seen_cells[it.cy*GRID + it.cx] = 1'b1;
      end
      default: begin
        if (walker_x == aim_x && walker_y == aim_y) begin
          r.status = ST_GOAL;
        end else begin
          best   = -1;
          best_h = 0;
          // up, down, left, right; strict less keeps the earliest on a tie
          for (k = 0; k < 4; k++) begin
            nx = int'(walker_x) + dx[k];
            ny = int'(walker_y) + dy[k];
            if (!on_grid(nx, ny)) continue;
            if (!open_cells[ny*GRID + nx] || seen_cells[ny*GRID + nx]) continue;
            h = (nx > aim_x ? nx - aim_x : aim_x - nx) + (ny > aim_y ? ny - aim_y : aim_y - ny);
            if (best < 0 || h < best_h) begin
              best   = k;
              best_h = h;
            end
          end
          if (best < 0) begin
            r.status = ST_STUCK;
          end else begin
            nx = int'(walker_x) + dx[best];
            ny = int'(walker_y) + dy[best];
            walker_x = COORD_W'(nx);
            walker_y = COORD_W'(ny);
            if (!free_walk) seen_cells[ny*GRID + nx] = 1'b1;
            r.status = ST_MOVED;
          end
        end
      end
    endcase
    r.pos_x = walker_x;
    r.pos_y = walker_y;
    expected_positions.push_back(r);
  endfunction

  function automatic walk_item_t mk_item(op_t o, int cx, int cy, bit wk, int gx, int gy, bit rt);
    walk_item_t it;
    it.op = o;
    it.cx = COORD_W'(cx);
    it.cy = COORD_W'(cy);
    it.wk = wk;
    it.gx = COORD_W'(gx);
    it.gy = COORD_W'(gy);
    it.rt = rt;
    return it;
  endfunction

  function automatic walk_item_t random_item();
    return mk_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 31),
                   $urandom_range(0, 1), $urandom_range(0, 31), $urandom_range(0, 31),
                   $urandom_range(0, 1));
  endfunction

  // valid stays high after acceptance; callers that pause call release_input first
  task automatic send_beat(walk_item_t it);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= it.op;
    cell_x   <= it.cx;
    cell_y   <= it.cy;
    walkable <= it.wk;
    goal_x   <= it.gx;
    goal_y   <= it.gy;
    retry    <= it.rt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_walker(it);
    beats_sent++;
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    release_input();
    while (expected_positions.size() != 0) @(posedge clk);
    // a walk start refill can still be running after the last result
    repeat (6) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    idle_en = 1'b1;
    // step before any start: reset position equals reset goal
    send_beat(mk_item(OP_STEP, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(OP_WRITE, 0, 0, 1, 31, 31, 1));
    send_beat(mk_item(OP_WRITE, 0, 1, 1, 0, 0, 0));
    send_beat(mk_item(OP_WRITE, 1, 0, 1, 0, 0, 0));
    send_beat(mk_item(OP_WRITE, 31, 31, 1, 0, 0, 0));
    send_beat(mk_item(OP_WRITE, 30, 31, 1, 0, 0, 0));
    // corner start, tie between down and right goes down, then stuck
    send_beat(mk_item(OP_START, 0, 0, 0, 31, 31, 0));
    send_beat(mk_item(OP_STEP, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(OP_STEP, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(OP_CLEAR, 31, 31, 1, 31, 31, 1));
    // reach the goal by a move, next step reports at goal
    send_beat(mk_item(OP_START, 0, 0, 0, 0, 1, 1));
    send_beat(mk_item(OP_STEP, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(OP_STEP, 0, 0, 0, 0, 0, 0));
    // retry walk revisits cells
    send_beat(mk_item(OP_START, 0, 1, 0, 31, 31, 1));
    send_beat(mk_item(OP_STEP, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(OP_STEP, 0, 0, 0, 0, 0, 0));
    // far corner, neighbours past the edge are blocked
    send_beat(mk_item(OP_START, 31, 31, 0, 0, 0, 0));
    send_beat(mk_item(OP_STEP, 31, 31, 1, 31, 31, 1));
    send_beat(mk_item(OP_STEP, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(OP_WRITE, 1, 0, 0, 0, 0, 0));
    // four open neighbours, equal distance on down and right
    send_beat(mk_item(OP_WRITE, 10, 9, 1, 0, 0, 0));
    send_beat(mk_item(OP_WRITE, 10, 11, 1, 0, 0, 0));
    send_beat(mk_item(OP_WRITE, 9, 10, 1, 0, 0, 0));
    send_beat(mk_item(OP_WRITE, 11, 10, 1, 0, 0, 0));
    send_beat(mk_item(OP_START, 10, 10, 0, 12, 12, 0));
    send_beat(mk_item(OP_STEP, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(OP_STEP, 0, 0, 0, 0, 0, 0));
    drain_results();
  endtask

  // one well-formed walk: paint a window, start inside it, step a while
  task automatic run_walk_episode();
    int         w, h, ox, oy, x, y, nsteps, density;
    walk_item_t it;
    w = $urandom_range(3, 7);
    h = $urandom_range(3, 7);
    ox = $urandom_range(0, GRID - w);
    oy = $urandom_range(0, GRID - h);
    case ($urandom_range(0, 5))
      0: ox = 0;
      1: ox = GRID - w;
      2: oy = 0;
      3: oy = GRID - h;
      default: ;
    endcase
    density = $urandom_range(55, 90);
    for (y = 0; y < h; y++) begin
      for (x = 0; x < w; x++) begin
        it = random_item();
        it.op = OP_WRITE;
        it.cx = COORD_W'(ox + x);
        it.cy = COORD_W'(oy + y);
        it.wk = ($urandom_range(0, 99) < density);
        send_beat(it);
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      it = random_item();
      it.op = OP_CLEAR;
      send_beat(it);
    end
    it = random_item();
    it.op = OP_START;
    it.cx = COORD_W'(ox + int'($urandom_range(0, w - 1)));
    it.cy = COORD_W'(oy + int'($urandom_range(0, h - 1)));
    if ($urandom_range(0, 4) < 3) begin
      it.gx = COORD_W'(ox + int'($urandom_range(0, w - 1)));
      it.gy = COORD_W'(oy + int'($urandom_range(0, h - 1)));
    end
    it.rt = ($urandom_range(0, 4) == 0);
    send_beat(it);
    nsteps = $urandom_range(4, 18);
    repeat (nsteps) begin
      it = random_item();
      if ($urandom_range(0, 9) != 0) it.op = OP_STEP;
      send_beat(it);
    end
  endtask

  task automatic test_output_backpressure();
    idle_en = 1'b0;
    hold_req_len = 150;
    hold_req_seq++;
    repeat (3) run_walk_episode();
    drain_results();
  endtask

  task automatic test_random_walks();
    while (beats_sent < 1750) begin
      idle_en = ($urandom_range(0, 3) != 0);
      run_walk_episode();
    end
    drain_results();
  endtask

  task automatic test_quiet_tail();
    idle_en = 1'b0;
    while (beats_sent < 1950) run_walk_episode();
    drain_results();
  endtask

  // receiver side: random stall bursts plus the requested long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall     <= 1'b0;
      hold_left     <= 0;
      hold_seen_seq <= 0;
      rx_burst_left <= 0;
    end else if (hold_req_seq != hold_seen_seq) begin
      hold_seen_seq <= hold_req_seq;
      hold_left     <= hold_req_len;
      out_stall     <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (rx_burst_left != 0) begin
      rx_burst_left <= rx_burst_left - 1;
      out_stall     <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      rx_burst_left <= $urandom_range(0, 8);
      out_stall     <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    walk_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_positions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: pos (%0d,%0d) status %0d", pos_x, pos_y, status);
      end else begin
        exp_r = expected_positions.pop_front();
        if (pos_x !== exp_r.pos_x || pos_y !== exp_r.pos_y || status !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected pos (%0d,%0d) status %s, got pos (%0d,%0d) status %0d",
                     exp_r.pos_x, exp_r.pos_y, exp_r.status.name(), pos_x, pos_y, status);
        end
      end
    end
  end

  initial begin
    foreach (open_cells[i]) open_cells[i] = 1'b0;
    foreach (seen_cells[i]) seen_cells[i] = 1'b0;
    walker_x     = '0;
    walker_y     = '0;
    aim_x        = '0;
    aim_y        = '0;
    free_walk    = 1'b0;
    mismatches   = 0;
    beats_sent   = 0;
    idle_en      = 1'b0;
    hold_req_len = 0;
    hold_req_seq = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_output_backpressure();
    test_random_walks();
    test_quiet_tail();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
